@@ rtl/interval_timer_with_prescaler_core_assert.svh @@
// Assertion macros for the interval timer core.
// Included by the top level; no other dependencies.
`ifndef INTERVAL_TIMER_WITH_PRESCALER_CORE_ASSERT_SVH
`define INTERVAL_TIMER_WITH_PRESCALER_CORE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising edge outside reset.
`define ITP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer assertion failed");
// Next-cycle implication.
`define ITP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer assertion failed");
`else
`define ITP_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define ITP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/itp_pkg.sv @@
// Shared types, register offsets and field positions for the interval timer.
// No dependencies; used by every module of the timer.
`timescale 1ns / 1ps

package itp_pkg;

    // Default width of the interval and count registers.
    localparam int COUNT_WIDTH_DEF = 32;

    // Item kinds.
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // Register byte offsets.
    localparam logic [5:0] OFF_IRQ_EN   = 6'h00;
    localparam logic [5:0] OFF_IRQ_ST   = 6'h04;
    localparam logic [5:0] OFF_CTRL     = 6'h20;
    localparam logic [5:0] OFF_INTERVAL = 6'h24;
    localparam logic [5:0] OFF_COUNT    = 6'h28;

    // Bit positions within the registers.
    localparam int IRQ_BIT       = 1;
    localparam int CTRL_RUN_BIT  = 0;
    localparam int CTRL_LOAD_BIT = 1;
    localparam int CTRL_SRC_LO   = 2;
    localparam int CTRL_SRC_HI   = 3;
    localparam int CTRL_PRE_LO   = 4;
    localparam int CTRL_PRE_HI   = 6;
    localparam int CTRL_ONE_BIT  = 7;

    // Input item.
    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  address;
        logic [31:0] write_data;
        logic [1:0]  tick_source;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_out;
    } t_out_item;

    // Interrupt state seen by the top level.
    typedef struct packed {
        logic irq_enable;
        logic irq_pending;
    } t_irq_status;

endpackage

@@ rtl/itp_in_reg.sv @@
// Input register of the interval timer: holds one accepted item.
// Depends on itp_pkg.
`timescale 1ns / 1ps

module itp_in_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  itp_pkg::t_in_item i_item,
    input  logic             i_take,
    output logic             o_stall,
    output logic             o_valid,
    output itp_pkg::t_in_item o_item
);
    import itp_pkg::*;

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;
    logic     w_open;

    // The register can take a transfer when empty or being drained.
    assign w_open  = !r_valid || i_take;
    assign o_stall = !w_open;
    assign n_valid = w_open ? i_valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_valid && w_open) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ rtl/itp_timer.sv @@
// Timer state and per-item logic: register file, prescaler and down counter.
// Depends on itp_pkg.
`timescale 1ns / 1ps

module itp_timer #(
    parameter int COUNT_WIDTH = itp_pkg::COUNT_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  itp_pkg::t_in_item   i_item,
    output itp_pkg::t_out_item  o_result,
    output itp_pkg::t_irq_status o_status
);
    import itp_pkg::*;

    logic                   r_irq_en,   n_irq_en;
    logic                   r_pending,  n_pending;
    logic                   r_run,      n_run;
    logic                   r_one_shot, n_one_shot;
    logic [1:0]             r_src,      n_src;
    logic [2:0]             r_pre_log,  n_pre_log;
    logic [6:0]             r_pre_cnt,  n_pre_cnt;
    logic [COUNT_WIDTH-1:0] r_interval, n_interval;
    logic [COUNT_WIDTH-1:0] r_count,    n_count;

    logic [31:0]            w_rd;
    logic [7:0]             w_pre_next;
    logic [7:0]             w_pre_limit;
    logic [COUNT_WIDTH-1:0] w_dec;
    logic [31:0]            w_wd;

    assign w_wd        = i_item.write_data;
    assign w_pre_next  = {1'b0, r_pre_cnt} + 8'd1;
    assign w_pre_limit = 8'd1 << r_pre_log;
    assign w_dec       = (r_count != '0) ? (r_count - COUNT_WIDTH'(1)) : '0;

    // Register read mux.
    always_comb begin
        w_rd = '0;
        case (i_item.address)
            OFF_IRQ_EN:   w_rd[IRQ_BIT] = r_irq_en;
            OFF_IRQ_ST:   w_rd[IRQ_BIT] = r_pending;
            OFF_CTRL:     w_rd = {24'd0, r_one_shot, r_pre_log, r_src, 1'b0, r_run};
            OFF_INTERVAL: w_rd = 32'(r_interval);
            OFF_COUNT:    w_rd = 32'(r_count);
            default:      w_rd = '0;
        endcase
    end

    // Next state for one item: bus write or source tick.
    always_comb begin
        n_irq_en   = r_irq_en;
        n_pending  = r_pending;
        n_run      = r_run;
        n_one_shot = r_one_shot;
        n_src      = r_src;
        n_pre_log  = r_pre_log;
        n_pre_cnt  = r_pre_cnt;
        n_interval = r_interval;
        n_count    = r_count;
        case (i_item.kind)
            KIND_WRITE: begin
                case (i_item.address)
                    OFF_IRQ_EN: begin
                        n_irq_en = w_wd[IRQ_BIT];
                    end
                    OFF_IRQ_ST: begin
                        // Write one to clear.
                        if (w_wd[IRQ_BIT]) begin
                            n_pending = 1'b0;
                        end
                    end
                    OFF_CTRL: begin
                        n_run      = w_wd[CTRL_RUN_BIT];
                        n_src      = w_wd[CTRL_SRC_HI:CTRL_SRC_LO];
                        n_pre_log  = w_wd[CTRL_PRE_HI:CTRL_PRE_LO];
                        n_one_shot = w_wd[CTRL_ONE_BIT];
                        // Reload strobe restarts the count from the interval.
                        if (w_wd[CTRL_LOAD_BIT]) begin
                            n_count   = r_interval;
                            n_pre_cnt = '0;
                        end
                    end
                    OFF_INTERVAL: begin
                        n_interval = COUNT_WIDTH'(w_wd);
                    end
                    default: begin
                    end
                endcase
            end
            KIND_TICK: begin
                if (r_run && (i_item.tick_source == r_src)) begin
                    if (w_pre_next >= w_pre_limit) begin
                        // Prescaler wraps: one count step.
                        n_pre_cnt = '0;
                        n_count   = w_dec;
                        if (w_dec == '0) begin
                            n_pending = 1'b1;
                            if (r_one_shot) begin
                                n_run = 1'b0;
                            end else begin
                                n_count = r_interval;
                            end
                        end
                    end else begin
                        n_pre_cnt = w_pre_next[6:0];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irq_en   <= 1'b0;
            r_pending  <= 1'b0;
            r_run      <= 1'b0;
            r_one_shot <= 1'b0;
            r_src      <= '0;
            r_pre_log  <= '0;
            r_pre_cnt  <= '0;
            r_interval <= '0;
            r_count    <= '0;
        end else if (i_fire) begin
            r_irq_en   <= n_irq_en;
            r_pending  <= n_pending;
            r_run      <= n_run;
            r_one_shot <= n_one_shot;
            r_src      <= n_src;
            r_pre_log  <= n_pre_log;
            r_pre_cnt  <= n_pre_cnt;
            r_interval <= n_interval;
            r_count    <= n_count;
        end
    end

    // Result: read data only for reads; interrupt line after the update.
    assign o_result.read_data = (i_item.kind == KIND_READ) ? w_rd : '0;
    assign o_result.irq_out   = n_irq_en && n_pending;

    assign o_status.irq_enable  = r_irq_en;
    assign o_status.irq_pending = r_pending;

endmodule

@@ rtl/itp_out_reg.sv @@
// Result register of the interval timer, holding one result until taken.
// Depends on itp_pkg.
`timescale 1ns / 1ps

module itp_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  itp_pkg::t_out_item i_result,
    input  logic               i_stall,
    output logic               o_free,
    output logic               o_valid,
    output itp_pkg::t_out_item o_item
);
    import itp_pkg::*;

    logic      r_valid;
    logic      n_valid;
    t_out_item r_item;

    // A slot is free when empty or when its result transfers this cycle.
    assign o_free  = !r_valid || !i_stall;
    assign n_valid = i_load || (r_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_result;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ rtl/interval_timer_with_prescaler_core.sv @@
// Top level of the interval timer with prescaler.
// Depends on itp_pkg, itp_in_reg, itp_timer, itp_out_reg and the assert header.
//
//   Channel | Handshake                  | Payload
//   --------+----------------------------+----------------------
//   in      | i_in_valid / o_in_stall    | i_in  (t_in_item)
//   out     | o_out_valid / i_out_stall  | o_out (t_out_item)
//
// One item per cycle sustained while the output does not stall; an item is held in the input
// register, and its result is registered in the result register, from which it transfers out.
// Each item is processed combinationally between the input and result registers.
// Synchronous active-low reset clears all timer registers and both valid flags.
// A stall on the output holds the result and, once the input register is full,
// stalls the input.
`timescale 1ns / 1ps

`include "interval_timer_with_prescaler_core_assert.svh"

module interval_timer_with_prescaler_core #(
    parameter int COUNT_WIDTH = itp_pkg::COUNT_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  itp_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output itp_pkg::t_out_item o_out
);
    import itp_pkg::*;

    logic        w_item_valid;
    t_in_item    w_item;
    logic        w_out_free;
    logic        w_fire;
    t_out_item   w_result;
    t_irq_status w_status;
    logic        w_irq_line;

    // Process the held item whenever the result register has room.
    assign w_fire = w_item_valid && w_out_free;

    // Interrupt line as given by the current timer state.
    assign w_irq_line = w_status.irq_enable && w_status.irq_pending;

    itp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (i_in),
        .i_take  (w_fire),
        .o_stall (o_in_stall),
        .o_valid (w_item_valid),
        .o_item  (w_item)
    );

    itp_timer #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_timer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (w_item),
        .o_result (w_result),
        .o_status (w_status)
    );

    itp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_fire),
        .i_result (w_result),
        .i_stall  (i_out_stall),
        .o_free   (w_out_free),
        .o_valid  (o_out_valid),
        .o_item   (o_out)
    );

    // The held result always reflects the current interrupt state.
    `ITP_ASSERT_NOW(a_irq_matches_state, i_clk, i_rst_n, o_out_valid, o_out.irq_out == w_irq_line)
    // The input only stalls while an item waits in the input register.
    `ITP_ASSERT_NOW(a_stall_only_when_full, i_clk, i_rst_n, o_in_stall, w_item_valid)
    // A processed item always leaves a result behind.
    `ITP_ASSERT_NEXT(a_fire_gives_result, i_clk, i_rst_n, w_fire, o_out_valid)

endmodule
